// ----- rtl/fpsha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpsha_pkg
// shared types and constants of the sha-1 based prf generator
// ----------------------------------------------------------------------------
package fpsha_pkg;

  localparam int KEY_BITS  = 160;
  localparam int KEY_WORDS = KEY_BITS / 32;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic load_key;
    logic start;
    logic round;
    logic finish;
    logic update_key;
  } dp_cmd_t;

  typedef struct packed {
    logic last_round;
  } dp_status_t;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

endpackage : fpsha_pkg
`default_nettype wire

// ----- rtl/fpsha_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpsha_datapath
// xkey register, key/seed adders and one sha-1 round per cycle
// ----------------------------------------------------------------------------
module fpsha_datapath (
  input  wire                       clk,
  input  wire                       rst,
  input  fpsha_pkg::dp_cmd_t        cmd,
  output fpsha_pkg::dp_status_t     status,
  input  wire [159:0]               data,
  input  wire                       seed_load,
  output logic [159:0]              digest
);
  import fpsha_pkg::*;

  logic [159:0] xkey;
  logic [159:0] seed;
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  w [16];
  logic [6:0]   rnd;

  logic [159:0] xval;
  logic [31:0]  f, k, t, wnext, wcur;

  assign xval = xkey + seed;
  assign wcur = w[0];
  assign wnext = rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + wcur;
  end

  assign status.last_round = (rnd == 7'd79);
  assign digest = {a, b, c, d, e};

  always_ff @(posedge clk) begin
    if (rst) begin
      xkey <= '0;
    end else if (cmd.load_key) begin
      xkey <= data;
    end else if (cmd.update_key) begin
      xkey <= xkey + digest + 160'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (seed_load) seed <= data;
    if (cmd.start) begin
      a <= IV0; b <= IV1; c <= IV2; d <= IV3; e <= IV4;
      rnd <= '0;
      for (int i = 0; i < 16; i++) begin
        w[i] <= (i < KEY_WORDS) ? xval[159 - 32*i -: 32] : 32'd0;
      end
    end else if (cmd.round) begin
      a <= t; b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
      rnd <= rnd + 7'd1;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnext;
    end else if (cmd.finish) begin
      a <= a + IV0; b <= b + IV1; c <= c + IV2; d <= d + IV3; e <= e + IV4;
    end
  end

endmodule : fpsha_datapath
`default_nettype wire

// ----- rtl/fpsha_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpsha_ctrl
// sequencer for load and generate words and the output register handshake
// ----------------------------------------------------------------------------
module fpsha_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       in_opcode,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      out_block,
  output logic                      capture,
  output fpsha_pkg::dp_cmd_t        cmd,
  input  fpsha_pkg::dp_status_t     status
);
  import fpsha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_ROUND  = 6'b000100,
    S_FINISH = 6'b001000,
    S_EMIT   = 6'b010000,
    S_WAIT   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   blk;
  logic   in_acc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    capture = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load_key = (in_opcode == OP_LOAD);
          if (in_opcode == OP_GENERATE) state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.last_round) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          capture = 1'b1;
          cmd.update_key = 1'b1;
          state_next = blk ? S_IDLE : S_START;
        end
      end
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blk <= 1'b0;
      out_valid <= 1'b0;
      out_block <= 1'b0;
    end else begin
      state <= state_next;
      if (capture) begin
        out_valid <= 1'b1;
        out_block <= blk;
        blk <= ~blk;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the input side stalls while a generate word is being worked
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> in_stall)
    else $error("input accepted during rounds");
  // capture happens only after a finish
  assert property (@(posedge clk) disable iff (rst)
    capture |-> $past(state == S_FINISH) || $past(state == S_EMIT))
    else $error("capture without finished compression");
  // a captured block never overwrites a pending one
  assert property (@(posedge clk) disable iff (rst)
    capture |-> !(out_valid && out_stall))
    else $error("output overwritten");

endmodule : fpsha_ctrl
`default_nettype wire

// ----- rtl/fips_prf_sha1_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fips_prf_sha1_generator
// fips 186-2 prf over the sha-1 compression with a 160-bit xkey
// ----------------------------------------------------------------------------
// a load word is written into xkey as it is accepted; a generate word runs a
// start step, 80 sha-1 rounds at one round per cycle, a finish step and an
// emit step for its first block and again for its second, and no new input
// word is taken until its second block is captured. rst is synchronous, clears
// xkey to zero and the control.
module fips_prf_sha1_generator (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         opcode,
  input  wire  [31:0] data_word_0,
  input  wire  [31:0] data_word_1,
  input  wire  [31:0] data_word_2,
  input  wire  [31:0] data_word_3,
  input  wire  [31:0] data_word_4,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_word_0,
  output logic [31:0] out_word_1,
  output logic [31:0] out_word_2,
  output logic [31:0] out_word_3,
  output logic [31:0] out_word_4,
  output logic        block_index,
  output logic        last
);
  import fpsha_pkg::*;

  dp_cmd_t      cmd;
  dp_status_t   status;
  logic [159:0] digest;
  logic         capture;
  logic         data_load;
  dp_cmd_t      dp_cmd;

  // the seed and key share one input capture
  always_comb begin
    dp_cmd = cmd;
    data_load = in_valid && !in_stall;
  end

  fpsha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(opcode),
    .out_valid(out_valid), .out_stall(out_stall), .out_block(block_index),
    .capture(capture), .cmd(cmd), .status(status)
  );

  fpsha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(dp_cmd), .status(status),
    .data({data_word_0, data_word_1, data_word_2, data_word_3, data_word_4}),
    .seed_load(data_load),
    .digest(digest)
  );

  always_ff @(posedge clk) begin
    if (capture) begin
      {out_word_0, out_word_1, out_word_2, out_word_3, out_word_4} <= digest;
    end
  end

  assign last = block_index;

endmodule : fips_prf_sha1_generator
`default_nettype wire

// ----- tb/fips_prf_sha1_generator_chk.sv -----
// ----------------------------------------------------------------------------
// fips_prf_sha1_generator_chk
// watches both channels, predicts the prf blocks from its own xkey copy and
// compares every output word with the oldest predicted block
// ----------------------------------------------------------------------------
module fips_prf_sha1_generator_chk
  import fpsha_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire         opcode,
  input  wire  [31:0] data_word_0,
  input  wire  [31:0] data_word_1,
  input  wire  [31:0] data_word_2,
  input  wire  [31:0] data_word_3,
  input  wire  [31:0] data_word_4,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [31:0] out_word_0,
  input  wire  [31:0] out_word_1,
  input  wire  [31:0] out_word_2,
  input  wire  [31:0] out_word_3,
  input  wire  [31:0] out_word_4,
  input  wire         block_index,
  input  wire         last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [159:0] blk;
    logic         idx;
    logic         lst;
  } prf_block_t;

  logic [159:0] xkey_model;
  prf_block_t   block_q[$];

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_compress(input logic [159:0] xval);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 80; i++) w[i] = 32'h0;
    for (int i = 0; i < 5; i++) w[i] = xval[159 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = IV0; b = IV1; c = IV2; d = IV3; e = IV4;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {IV0 + a, IV1 + b, IV2 + c, IV3 + d, IV4 + e};
  endfunction

  assign pending = block_q.size();

  always @(posedge clk) begin
    logic [159:0] din, wblk, got;
    prf_block_t   exp_b;
    if (rst) begin
      xkey_model <= '0;
      errors     <= 0;
      block_q.delete();
    end else begin
      din = {data_word_0, data_word_1, data_word_2, data_word_3, data_word_4};
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          xkey_model <= din;
        end else begin
          wblk = xkey_model;
          for (int j = 0; j < 2; j++) begin
            got  = sha1_compress(wblk + din);
            block_q.push_back('{blk: got, idx: j[0], lst: (j == 1)});
            wblk = wblk + got + 160'd1;
          end
          xkey_model <= wblk;
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_word_0, out_word_1, out_word_2, out_word_3, out_word_4};
        if (block_q.size() == 0) begin
          $display("%0t unexpected word: actual %h idx %b last %b",
                   $time, got, block_index, last);
          errors <= errors + 1;
        end else begin
          exp_b = block_q.pop_front();
          if (got !== exp_b.blk || block_index !== exp_b.idx || last !== exp_b.lst) begin
            $display("%0t expected %h idx %b last %b, actual %h idx %b last %b",
                     $time, exp_b.blk, exp_b.idx, exp_b.lst, got, block_index, last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/fips_prf_sha1_generator_tb.sv -----
// ----------------------------------------------------------------------------
// fips_prf_sha1_generator_tb
// directed and random key loads and generate words with random idling on both
// sides and one long output hold-off; a checker predicts and compares
// ----------------------------------------------------------------------------
module fips_prf_sha1_generator_tb;
  import fpsha_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        opcode = OP_LOAD;
  logic [31:0] dw0 = '0, dw1 = '0, dw2 = '0, dw3 = '0, dw4 = '0;
  logic        out_stall = 1'b0;
  wire         in_stall, out_valid, block_index, last;
  wire  [31:0] ow0, ow1, ow2, ow3, ow4;
  int          errors, pending;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  always #6 clk = ~clk;

  fips_prf_sha1_generator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_word_0(dw0), .data_word_1(dw1), .data_word_2(dw2),
    .data_word_3(dw3), .data_word_4(dw4), .out_valid(out_valid),
    .out_stall(out_stall), .out_word_0(ow0), .out_word_1(ow1),
    .out_word_2(ow2), .out_word_3(ow3), .out_word_4(ow4),
    .block_index(block_index), .last(last)
  );

  fips_prf_sha1_generator_chk u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_word_0(dw0), .data_word_1(dw1), .data_word_2(dw2),
    .data_word_3(dw3), .data_word_4(dw4), .out_valid(out_valid),
    .out_stall(out_stall), .out_word_0(ow0), .out_word_1(ow1),
    .out_word_2(ow2), .out_word_3(ow3), .out_word_4(ow4),
    .block_index(block_index), .last(last), .errors(errors), .pending(pending)
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [159:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    {dw0, dw1, dw2, dw3, dw4} <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // output side stall bursts, plus one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        hold_req  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #12000000;
    $display("fips_prf_sha1_generator: mismatch");
    $finish;
  end

  initial begin
    logic [159:0] v;
    int guard;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // generate from the reset key, then key extremes with seed extremes
    send_word(OP_GENERATE, '0);
    send_word(OP_GENERATE, {160{1'b1}});
    send_word(OP_LOAD, {160{1'b1}});
    send_word(OP_GENERATE, {160{1'b1}});
    send_word(OP_GENERATE, 160'd1);
    send_word(OP_LOAD, '0);
    send_word(OP_GENERATE, '0);
    send_word(OP_LOAD, {32'h80000000, 128'h0});
    send_word(OP_GENERATE, {32'h80000000, 128'h0});
    send_word(OP_LOAD, {128'h0, 32'hFFFFFFFF});
    send_word(OP_GENERATE, 160'h1);
    send_word(OP_LOAD, 160'h0123456789ABCDEF0123456789ABCDEF01234567);
    send_word(OP_GENERATE, 160'hFEDCBA9876543210FEDCBA9876543210FEDCBA98);
    send_word(OP_LOAD, 160'h0123456789ABCDEF0123456789ABCDEF01234567);
    hold_req <= 1'b1;
    repeat (6) send_word(OP_GENERATE, {$urandom(), $urandom(), $urandom(),
                                       $urandom(), $urandom()});
    for (int n = 0; n < 730; n++) begin
      if (n == 650) quiet = 1'b1;
      v = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
      send_word(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_GENERATE, v);
    end
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("fips_prf_sha1_generator: match");
    end else begin
      $display("fips_prf_sha1_generator: mismatch");
    end
    $finish;
  end

endmodule
